>>> rtl/zsed_pkg.sv
`default_nettype none
package zsed_pkg;

  localparam logic [31:0] SIGNATURE_VALUE = 32'h04034b50;
  localparam logic [15:0] STORED_METHOD   = 16'h0000;

  // byte positions inside the signature and the fixed 26-byte header
  localparam logic [4:0] SIG_LAST_IDX   = 5'd3;
  localparam logic [4:0] HDR_METHOD_LO  = 5'd4;
  localparam logic [4:0] HDR_METHOD_HI  = 5'd5;
  localparam logic [4:0] HDR_STORED_B0  = 5'd14;
  localparam logic [4:0] HDR_STORED_B1  = 5'd15;
  localparam logic [4:0] HDR_STORED_B2  = 5'd16;
  localparam logic [4:0] HDR_STORED_B3  = 5'd17;
  localparam logic [4:0] HDR_PLAIN_B0   = 5'd18;
  localparam logic [4:0] HDR_PLAIN_B1   = 5'd19;
  localparam logic [4:0] HDR_PLAIN_B2   = 5'd20;
  localparam logic [4:0] HDR_PLAIN_B3   = 5'd21;
  localparam logic [4:0] HDR_NAME_LO    = 5'd22;
  localparam logic [4:0] HDR_NAME_HI    = 5'd23;
  localparam logic [4:0] HDR_EXTRA_LO   = 5'd24;
  localparam logic [4:0] HDR_EXTRA_HI   = 5'd25;

  // result queue depth; two free slots are needed to take a byte
  localparam int ZSED_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    K_NAME       = 3'd0,
    K_PAYLOAD    = 3'd1,
    K_EMPTY      = 3'd2,
    K_COMPRESSED = 3'd3,
    K_SIZE       = 3'd4,
    K_END        = 3'd5
  } kind_t;

  typedef enum logic [6:0] {
    PH_SIG     = 7'b0000001,
    PH_HDR     = 7'b0000010,
    PH_NAME    = 7'b0000100,
    PH_EXTRA   = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_ENDED   = 7'b0100000,
    PH_HALTED  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       is_last;
  } zsed_res_t;

  // up to two results per accepted byte; second only ever follows a first
  typedef struct packed {
    logic      push0;
    logic      push1;
    zsed_res_t res0;
    zsed_res_t res1;
  } zsed_push_t;

endpackage
`default_nettype wire

>>> rtl/zsed_ifs.sv
`default_nettype none
interface zsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink   (input valid, input archive_byte, output ready);
endinterface

interface zsed_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output kind, output data_byte, output is_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

>>> rtl/zip_stored_entry_deframer.sv
// Stored-entry deframer for a zip-style archive byte stream.
//
// in_bytes  : one archive byte per item (valid/ready).
// out_items : results {kind, data_byte, is_last}. Name bytes and stored
//             payload bytes are passed on, each entry's last name byte and
//             last payload byte marked; an empty entry, a compressed entry,
//             a size mismatch and the archive end each give one marker item.
//
// A result is registered in the result queue and offered on out_items once
// the items ahead of it are taken. Bytes are taken at one per cycle while
// the queue has room. A last name byte that completes the header and raises
// a marker gives two results; the second follows the first through the queue.
//
// The parser updates its phase and counters for each accepted byte and
// pushes its results into a small queue (ZSED_QUEUE_DEPTH entries). in_bytes
// is ready while the queue has two free slots, so a stalled receiver fills
// the queue and then holds the sender off; nothing is dropped.
// Reset: synchronous, active low; back to the signature phase, queue empty.
// After an archive end or an error the block consumes and drops every byte
// until reset.
`default_nettype none
module zip_stored_entry_deframer
  import zsed_pkg::*;
#(
  parameter int QUEUE_DEPTH = ZSED_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  zsed_in_if.sink    in_bytes,
  zsed_out_if.source out_items
);

  zsed_push_t push;   // results of the byte taken this cycle
  logic       room;   // queue can take a full pair

  zsed_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .room     (room),
    .in_bytes (in_bytes),
    .push     (push)
  );

  zsed_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_items (out_items)
  );

endmodule
`default_nettype wire

>>> rtl/zsed_parser.sv
`default_nettype none
module zsed_parser
  import zsed_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   room,
  zsed_in_if.sink     in_bytes,
  output zsed_push_t  push
);

  phase_t      phase_r,   phase_nxt;
  logic [4:0]  idx_r,     idx_nxt;
  logic [31:0] sig_r,     sig_nxt;
  logic [15:0] method_r,  method_nxt;
  logic [31:0] stored_r,  stored_nxt;
  logic [31:0] plain_r,   plain_nxt;
  logic [15:0] name_r,    name_nxt;
  logic [15:0] extra_r,   extra_nxt;
  logic [31:0] payload_r, payload_nxt;

  logic        in_fire;
  logic [7:0]  b;
  logic [31:0] sig_shifted;

  // header check outcome, depends only on stored header fields
  logic        chk_emit;
  kind_t       chk_kind;
  phase_t      chk_phase;
  zsed_res_t   chk_res;

  assign in_bytes.ready = room;
  assign in_fire        = in_bytes.valid && room;
  assign b              = in_bytes.archive_byte;
  assign sig_shifted    = {b, sig_r[31:8]};

  always_comb begin
    chk_emit  = 1'b1;
    chk_kind  = K_EMPTY;
    chk_phase = PH_SIG;
    if (method_r != STORED_METHOD) begin
      chk_kind  = K_COMPRESSED;
      chk_phase = PH_HALTED;
    end else if (stored_r != plain_r) begin
      chk_kind  = K_SIZE;
      chk_phase = PH_HALTED;
    end else if (stored_r == 32'd0) begin
      chk_kind  = K_EMPTY;
      chk_phase = PH_SIG;
    end else begin
      chk_emit  = 1'b0;
      chk_phase = PH_PAYLOAD;
    end
    chk_res = '{kind: chk_kind, data_byte: 8'd0, is_last: 1'b0};
  end

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    sig_nxt     = sig_r;
    method_nxt  = method_r;
    stored_nxt  = stored_r;
    plain_nxt   = plain_r;
    name_nxt    = name_r;
    extra_nxt   = extra_r;
    payload_nxt = payload_r;
    push        = '0;

    if (in_fire) begin
      unique case (phase_r)
        PH_SIG: begin
          sig_nxt = sig_shifted;
          idx_nxt = idx_r + 5'd1;
          if (idx_r == SIG_LAST_IDX) begin
            idx_nxt = 5'd0;
            if (sig_shifted == SIGNATURE_VALUE) begin
              phase_nxt = PH_HDR;
            end else begin
              phase_nxt  = PH_ENDED;
              push.push0 = 1'b1;
              push.res0  = '{kind: K_END, data_byte: 8'd0, is_last: 1'b0};
            end
          end
        end
        PH_HDR: begin
          unique case (idx_r)
            HDR_METHOD_LO: method_nxt[7:0]   = b;
            HDR_METHOD_HI: method_nxt[15:8]  = b;
            HDR_STORED_B0: stored_nxt[7:0]   = b;
            HDR_STORED_B1: stored_nxt[15:8]  = b;
            HDR_STORED_B2: stored_nxt[23:16] = b;
            HDR_STORED_B3: stored_nxt[31:24] = b;
            HDR_PLAIN_B0:  plain_nxt[7:0]    = b;
            HDR_PLAIN_B1:  plain_nxt[15:8]   = b;
            HDR_PLAIN_B2:  plain_nxt[23:16]  = b;
            HDR_PLAIN_B3:  plain_nxt[31:24]  = b;
            HDR_NAME_LO:   name_nxt[7:0]     = b;
            HDR_NAME_HI:   name_nxt[15:8]    = b;
            HDR_EXTRA_LO:  extra_nxt[7:0]    = b;
            HDR_EXTRA_HI:  extra_nxt[15:8]   = b;
            default: ;
          endcase
          idx_nxt = idx_r + 5'd1;
          if (idx_r == HDR_EXTRA_HI) begin
            idx_nxt = 5'd0;
            if (name_nxt != 16'd0) begin
              phase_nxt = PH_NAME;
            end else if (extra_nxt != 16'd0) begin
              phase_nxt = PH_EXTRA;
            end else begin
              phase_nxt   = chk_phase;
              push.push0  = chk_emit;
              push.res0   = chk_res;
              payload_nxt = stored_r;
              sig_nxt     = 32'd0;
            end
          end
        end
        PH_NAME: begin
          push.push0 = 1'b1;
          push.res0  = '{kind: K_NAME, data_byte: b, is_last: (name_r == 16'd1)};
          name_nxt   = name_r - 16'd1;
          if (name_r == 16'd1) begin
            if (extra_r != 16'd0) begin
              phase_nxt = PH_EXTRA;
            end else begin
              // header completes on the last name byte: check outcome follows it
              phase_nxt   = chk_phase;
              push.push1  = chk_emit;
              push.res1   = chk_res;
              payload_nxt = stored_r;
              sig_nxt     = 32'd0;
            end
          end
        end
        PH_EXTRA: begin
          extra_nxt = extra_r - 16'd1;
          if (extra_r == 16'd1) begin
            phase_nxt   = chk_phase;
            push.push0  = chk_emit;
            push.res0   = chk_res;
            payload_nxt = stored_r;
            sig_nxt     = 32'd0;
          end
        end
        PH_PAYLOAD: begin
          push.push0  = 1'b1;
          push.res0   = '{kind: K_PAYLOAD, data_byte: b, is_last: (payload_r == 32'd1)};
          payload_nxt = payload_r - 32'd1;
          if (payload_r == 32'd1) begin
            phase_nxt = PH_SIG;
            idx_nxt   = 5'd0;
            sig_nxt   = 32'd0;
          end
        end
        PH_ENDED, PH_HALTED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      idx_r     <= 5'd0;
      sig_r     <= 32'd0;
      method_r  <= 16'd0;
      stored_r  <= 32'd0;
      plain_r   <= 32'd0;
      name_r    <= 16'd0;
      extra_r   <= 16'd0;
      payload_r <= 32'd0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      sig_r     <= sig_nxt;
      method_r  <= method_nxt;
      stored_r  <= stored_nxt;
      plain_r   <= plain_nxt;
      name_r    <= name_nxt;
      extra_r   <= extra_nxt;
      payload_r <= payload_nxt;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALTED |=> phase_r == PH_HALTED)
    else $error("halted phase left without reset");

  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENDED || phase_r == PH_HALTED) |-> !push.push0 && !push.push1)
    else $error("result produced after archive end or halt");

  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0 && push.res0.kind == K_NAME && phase_r == PH_NAME)
    else $error("second result without a leading name byte");

endmodule
`default_nettype wire

>>> rtl/zsed_out_queue.sv
`default_nettype none
module zsed_out_queue
  import zsed_pkg::*;
#(
  parameter int DEPTH = ZSED_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire zsed_push_t  push,
  output logic             room,
  zsed_out_if.source       out_items
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  zsed_res_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;
  zsed_res_t       head;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr1  = ptr_inc(wr_r);
  assign head = mem_r[rd_r];
  assign pop  = out_items.valid && out_items.ready;
  assign room = cnt_r <= CW'(DEPTH - 2);

  assign out_items.valid     = cnt_r != '0;
  assign out_items.kind      = head.kind;
  assign out_items.data_byte = head.data_byte;
  assign out_items.is_last   = head.is_last;

  always_comb begin
    wr_nxt  = push.push1 ? ptr_inc(wr1) : (push.push0 ? wr1 : wr_r);
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.push0 && wr_r == PW'(i)) begin
        mem_r[i] <= push.res0;
      end else if (push.push1 && wr1 == PW'(i)) begin
        mem_r[i] <= push.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> cnt_r <= CW'(DEPTH - 2))
    else $error("push into queue without two free slots");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_items.valid && !out_items.ready |=> out_items.valid && $stable(out_items.kind)
      && $stable(out_items.data_byte) && $stable(out_items.is_last))
    else $error("stalled result item changed or dropped");

endmodule
`default_nettype wire

>>> tb/sv/zsed_checker.sv
module zsed_checker
  import zsed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_archive_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_data_byte,
  input  logic       out_is_last,
  output int         fail_count,
  output int         expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  // deframer state, mirrored byte by byte
  phase_t      ph;
  logic [4:0]  pos;
  logic [31:0] sig_window;
  logic [15:0] method;
  logic [31:0] csize;
  logic [31:0] usize;
  logic [15:0] name_due;
  logic [15:0] extra_due;
  logic [31:0] payload_due;

  zsed_res_t due_items[$];
  int        mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_result(input kind_t k, input logic [7:0] d, input logic l);
    zsed_res_t r;
    r.kind      = k;
    r.data_byte = d;
    r.is_last   = l;
    due_items.push_back(r);
  endtask

  task automatic restart_signature();
    ph         = PH_SIG;
    pos        = '0;
    sig_window = '0;
  endtask

  // whole local header taken in: method first, then sizes, then empty check
  task automatic close_header();
    if (method != STORED_METHOD) begin
      ph = PH_HALTED;
      queue_result(K_COMPRESSED, 8'h00, 1'b0);
    end else if (csize != usize) begin
      ph = PH_HALTED;
      queue_result(K_SIZE, 8'h00, 1'b0);
    end else if (csize == 32'd0) begin
      restart_signature();
      queue_result(K_EMPTY, 8'h00, 1'b0);
    end else begin
      payload_due = csize;
      ph          = PH_PAYLOAD;
    end
  endtask

  task automatic leave_name();
    if (extra_due != 16'd0) ph = PH_EXTRA;
    else close_header();
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    case (ph)
      PH_SIG: begin
        sig_window = {b, sig_window[31:8]};
        if (pos == SIG_LAST_IDX) begin
          if (sig_window == SIGNATURE_VALUE) begin
            ph  = PH_HDR;
            pos = '0;
          end else begin
            ph = PH_ENDED;
            queue_result(K_END, 8'h00, 1'b0);
          end
        end else begin
          pos = pos + 5'd1;
        end
      end
      PH_HDR: begin
        case (pos)
          HDR_METHOD_LO: method[7:0]     = b;
          HDR_METHOD_HI: method[15:8]    = b;
          HDR_STORED_B0: csize[7:0]      = b;
          HDR_STORED_B1: csize[15:8]     = b;
          HDR_STORED_B2: csize[23:16]    = b;
          HDR_STORED_B3: csize[31:24]    = b;
          HDR_PLAIN_B0:  usize[7:0]      = b;
          HDR_PLAIN_B1:  usize[15:8]     = b;
          HDR_PLAIN_B2:  usize[23:16]    = b;
          HDR_PLAIN_B3:  usize[31:24]    = b;
          HDR_NAME_LO:   name_due[7:0]   = b;
          HDR_NAME_HI:   name_due[15:8]  = b;
          HDR_EXTRA_LO:  extra_due[7:0]  = b;
          HDR_EXTRA_HI:  extra_due[15:8] = b;
          default: ;
        endcase
        if (pos == HDR_EXTRA_HI) begin
          pos = '0;
          if (name_due != 16'd0) ph = PH_NAME;
          else leave_name();
        end else begin
          pos = pos + 5'd1;
        end
      end
      PH_NAME: begin
        queue_result(K_NAME, b, name_due == 16'd1);
        name_due = name_due - 16'd1;
        if (name_due == 16'd0) leave_name();
      end
      PH_EXTRA: begin
        extra_due = extra_due - 16'd1;
        if (extra_due == 16'd0) close_header();
      end
      PH_PAYLOAD: begin
        queue_result(K_PAYLOAD, b, payload_due == 32'd1);
        payload_due = payload_due - 32'd1;
        if (payload_due == 32'd0) restart_signature();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    zsed_res_t want;
    if (!rst_n) begin
      restart_signature();
      method      = '0;
      csize       = '0;
      usize       = '0;
      name_due    = '0;
      extra_due   = '0;
      payload_due = '0;
      due_items.delete();
    end else begin
      if (in_valid && in_ready) deframe_byte(in_archive_byte);
      if (out_valid && out_ready) begin
        if (due_items.size() == 0) begin
          report_mismatch($sformatf("unexpected item kind %0d byte %02h last %0b",
                                    out_kind, out_data_byte, out_is_last));
        end else begin
          want = due_items.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %02h, want %02h",
                                      out_data_byte, want.data_byte));
          if (out_is_last !== want.is_last)
            report_mismatch($sformatf("is_last %0b, want %0b", out_is_last, want.is_last));
        end
      end
    end
    expected_left <= due_items.size();
  end

endmodule

>>> tb/sv/tb_zip_stored_entry_deframer.sv
module tb_zip_stored_entry_deframer;
  import zsed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 8;
  localparam int HEADER_BYTES   = 26;
  localparam int RANDOM_BYTES   = 400;
  localparam int DRAIN_CYCLES   = 16;
  // longest legal quiet stretch is a sender gap plus a receiver stall; allow
  // many times that
  localparam int WATCHDOG_LIMIT = 2000;

  // ways of leaving the normal entry loop; the block only recovers from
  // any of them through reset, so each run closes with exactly one
  typedef enum int {
    CLOSE_BAD_SIGNATURE,
    CLOSE_COMPRESSED,
    CLOSE_SIZE_MISMATCH
  } closing_t;

  logic clk = 1'b0;
  logic rst_n;

  zsed_in_if  in_bytes ();
  zsed_out_if out_items ();

  int mismatch_total;
  int results_due;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  bit sender_calm    = 1'b0;
  bit receiver_calm  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  zip_stored_entry_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bytes  (in_bytes),
    .out_items (out_items)
  );

  zsed_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_bytes.valid),
    .in_ready        (in_bytes.ready),
    .in_archive_byte (in_bytes.archive_byte),
    .out_valid       (out_items.valid),
    .out_ready       (out_items.ready),
    .out_kind        (out_items.kind),
    .out_data_byte   (out_items.data_byte),
    .out_is_last     (out_items.is_last),
    .fail_count      (mismatch_total),
    .expected_left   (results_due)
  );

  // Idle length: mostly none or short, now and then a long one.
  // While calm, never idle, so back-to-back stretches occur as well.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Skew towards the all-zero and all-one bytes so both turn up often.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Offer one byte, changing inputs only at the falling edge, and hold it
  // until the rising edge at which the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 199) == 0) sender_calm = !sender_calm;
    gap = pick_gap(sender_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_bytes.valid        <= 1'b0;
      in_bytes.archive_byte <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_bytes.valid        <= 1'b1;
    in_bytes.archive_byte <= b;
    do @(posedge clk); while (!in_bytes.ready);
    bytes_sent++;
  endtask

  // Drop valid, then hold off until every predicted item has come out.
  task automatic wait_results_drained();
    @(negedge clk);
    in_bytes.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Signature, 26 fixed header bytes with random filler outside the fields
  // the block reads, then name, extra field and payload.
  task automatic send_entry(input logic [15:0] method, input logic [31:0] csize,
                            input logic [31:0] usize, input logic [15:0] name_len,
                            input logic [15:0] extra_len, input int payload_len);
    logic [7:0] hdr [HEADER_BYTES];
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = pick_byte();
    hdr[HDR_METHOD_LO] = method[7:0];
    hdr[HDR_METHOD_HI] = method[15:8];
    hdr[HDR_STORED_B0] = csize[7:0];
    hdr[HDR_STORED_B1] = csize[15:8];
    hdr[HDR_STORED_B2] = csize[23:16];
    hdr[HDR_STORED_B3] = csize[31:24];
    hdr[HDR_PLAIN_B0]  = usize[7:0];
    hdr[HDR_PLAIN_B1]  = usize[15:8];
    hdr[HDR_PLAIN_B2]  = usize[23:16];
    hdr[HDR_PLAIN_B3]  = usize[31:24];
    hdr[HDR_NAME_LO]   = name_len[7:0];
    hdr[HDR_NAME_HI]   = name_len[15:8];
    hdr[HDR_EXTRA_LO]  = extra_len[7:0];
    hdr[HDR_EXTRA_HI]  = extra_len[15:8];
    for (int i = 0; i < 4; i++) send_byte(8'(SIGNATURE_VALUE >> (8 * i)));
    for (int i = 0; i < HEADER_BYTES; i++) send_byte(hdr[i]);
    for (int i = 0; i < int'(name_len); i++) send_byte(pick_byte());
    for (int i = 0; i < int'(extra_len); i++) send_byte(pick_byte());
    for (int i = 0; i < payload_len; i++) send_byte(pick_byte());
  endtask

  // Well-formed stored entry with random lengths: mostly short, now and
  // then long enough to set the upper length bytes.
  task automatic send_random_entry();
    logic [15:0] name_len;
    logic [15:0] extra_len;
    int          payload_len;
    int          r;
    name_len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    if ($urandom_range(0, 39) == 0) name_len = 16'($urandom_range(256, 300));
    extra_len = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    if ($urandom_range(0, 39) == 0) extra_len = 16'($urandom_range(256, 270));
    r = $urandom_range(0, 99);
    if (r < 20)      payload_len = 0;
    else if (r < 88) payload_len = $urandom_range(1, 24);
    else if (r < 98) payload_len = $urandom_range(25, 400);
    else             payload_len = $urandom_range(600, 1100);
    send_entry(STORED_METHOD, payload_len, payload_len, name_len, extra_len, payload_len);
  endtask

  // Close the archive one way or another, then feed bytes that must all be
  // swallowed without a single item.
  task automatic send_closing_sequence();
    closing_t    how;
    logic [15:0] method;
    logic [31:0] csize;
    logic [31:0] usize;
    logic [15:0] name_len;
    logic [15:0] extra_len;
    logic [7:0]  good;
    int          at;
    how = closing_t'($urandom_range(0, 2));
    // where the header completes: on the fixed part, the last name byte
    // (name item then error item from one byte) or the last extra byte
    at = $urandom_range(0, 2);
    name_len  = (at == 1) ? 16'($urandom_range(1, 4)) : 16'd0;
    extra_len = (at == 2) ? 16'($urandom_range(1, 4)) : 16'd0;
    case (how)
      CLOSE_BAD_SIGNATURE: begin
        // match a prefix, spoil one byte, then finish the four
        at = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          good = 8'(SIGNATURE_VALUE >> (8 * i));
          if (i < at) send_byte(good);
          else if (i == at) send_byte(good ^ 8'($urandom_range(1, 255)));
          else send_byte(pick_byte());
        end
      end
      CLOSE_COMPRESSED: begin
        // sizes left random, so a compressed entry often has them differ too
        case ($urandom_range(0, 2))
          0:       method = 16'hFFFF;
          1:       method = 16'h0008;
          default: method = 16'($urandom_range(1, 65535));
        endcase
        csize = $urandom();
        usize = ($urandom_range(0, 1) == 0) ? csize : 32'($urandom());
        send_entry(method, csize, usize, name_len, extra_len, 0);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) begin
          csize = 32'hFFFF_FFFF;
          usize = 32'hFFFF_FFFE;
        end else begin
          csize = $urandom();
          usize = csize ^ (32'h1 << $urandom_range(0, 31));
        end
        send_entry(STORED_METHOD, csize, usize, name_len, extra_len, 0);
      end
    endcase
    send_entry(STORED_METHOD, 32'd3, 32'd3, 16'd1, 16'd0, 3);
    repeat (24) send_byte(pick_byte());
  endtask

  // Receiver: stall at random, with calm stretches of steady ready.
  initial begin
    int stall;
    stall = 0;
    out_items.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) receiver_calm = !receiver_calm;
      if (stall > 0) begin
        out_items.ready <= 1'b0;
        stall = stall - 1;
      end else begin
        out_items.ready <= 1'b1;
        stall = pick_gap(receiver_calm);
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_bytes.valid && in_bytes.ready) || (out_items.valid && out_items.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_bytes.valid        = 1'b0;
    in_bytes.archive_byte = 8'h00;
    rst_n                 = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte name and one-byte payload: both items carry the last marker
    send_entry(STORED_METHOD, 32'd1, 32'd1, 16'd1, 16'd0, 1);
    // no name, no extra, nothing stored: empty marker on the last header byte
    send_entry(STORED_METHOD, 32'd0, 32'd0, 16'd0, 16'd0, 0);
    // last name byte completes the header: name item, then empty marker
    send_entry(STORED_METHOD, 32'd0, 32'd0, 16'd3, 16'd0, 0);
    // empty marker raised by the last extra byte
    send_entry(STORED_METHOD, 32'd0, 32'd0, 16'd0, 16'd2, 0);
    // name and extra both present ahead of a short payload
    send_entry(STORED_METHOD, 32'd5, 32'd5, 16'd2, 16'd3, 5);
    // no name at all, payload only
    send_entry(STORED_METHOD, 32'd4, 32'd4, 16'd0, 16'd0, 4);
    // lengths reaching into the second byte of every length field
    send_entry(STORED_METHOD, 32'd258, 32'd258, 16'd257, 16'd256, 258);

    // hold off once until the block has emptied out
    wait_results_drained();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      send_random_entry();
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end

    send_closing_sequence();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && results_due == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/zsed_pkg.sv
rtl/zsed_ifs.sv
rtl/zsed_parser.sv
rtl/zsed_out_queue.sv
rtl/zip_stored_entry_deframer.sv
tb/sv/zsed_checker.sv
tb/sv/tb_zip_stored_entry_deframer.sv
